// File: sv/bal_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bal_pkg;

    localparam int CAPACITY = 1024;
    localparam int ADDR_W   = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int POS_W    = 11;
    localparam int WORD_W   = 32;
    localparam int CMP_W    = (POS_W > CNT_W) ? POS_W : CNT_W;

    typedef enum logic [3:0] {
        ACT_READ       = 4'd0,
        ACT_WRITE      = 4'd1,
        ACT_INSERT     = 4'd2,
        ACT_ERASE      = 4'd3,
        ACT_PUSH_BACK  = 4'd4,
        ACT_PUSH_FRONT = 4'd5,
        ACT_POP_BACK   = 4'd6,
        ACT_POP_FRONT  = 4'd7,
        ACT_CLEAR      = 4'd8,
        ACT_READ_LAST  = 4'd9
    } action_t;

    typedef enum logic [1:0] {
        STS_OK    = 2'd0,
        STS_FULL  = 2'd1,
        STS_RANGE = 2'd2,
        STS_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_SHIFT,
        ST_FINISH
    } ctrl_state_t;

    typedef struct packed {
        logic [3:0]               action;
        logic [POS_W-1:0]         position;
        logic signed [WORD_W-1:0] item_value;
    } req_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] read_word;
        status_t                  status;
        logic [CNT_W-1:0]         count;
        logic                     is_empty;
    } rsp_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
    } ram_cmd_t;

endpackage

`default_nettype wire

// File: sv/bal_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bal_ram
    import bal_pkg::*;
(
    input  wire logic              clk,
    input  wire ram_cmd_t          cmd,
    output logic [WORD_W-1:0]      rd_data
);

    logic [WORD_W-1:0] mem [CAPACITY];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data <= mem[cmd.rd_addr];
        end
    end

endmodule

`default_nettype wire

// File: sv/bal_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module bal_ctrl
    import bal_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              req_valid,
    output logic                   req_ready,
    input  wire req_t              req,
    output logic                   res_valid,
    input  wire logic              res_take,
    output rsp_t                   res,
    output ram_cmd_t               cmd,
    input  wire logic [WORD_W-1:0] rd_data
);

    ctrl_state_t       state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [WORD_W-1:0] word_reg, word_next;
    status_t           status_reg, status_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [WORD_W-1:0] val_reg, val_next;
    logic [ADDR_W-1:0] cur_reg, cur_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic              pend_valid_reg, pend_valid_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic              open_reg, open_next;
    logic              capture_reg, capture_next;

    logic [CMP_W-1:0]  pos_ext;
    logic [CMP_W-1:0]  cnt_ext;
    logic              full;
    logic              empty;
    logic [ADDR_W-1:0] last_addr;

    assign pos_ext   = CMP_W'(req.position);
    assign cnt_ext   = CMP_W'(count_reg);
    assign full      = (count_reg >= CNT_W'(CAPACITY));
    assign empty     = (count_reg == '0);
    assign last_addr = ADDR_W'(count_reg - CNT_W'(1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg      <= word_next;
        status_reg    <= status_next;
        pos_reg       <= pos_next;
        val_reg       <= val_next;
        cur_reg       <= cur_next;
        rem_reg       <= rem_next;
        pend_addr_reg <= pend_addr_next;
        open_reg      <= open_next;
        capture_reg   <= capture_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        word_next       = word_reg;
        status_next     = status_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        cur_next        = cur_reg;
        rem_next        = rem_reg;
        pend_valid_next = 1'b0;
        pend_addr_next  = pend_addr_reg;
        open_next       = open_reg;
        capture_next    = capture_reg;
        cmd             = '0;
        req_ready       = 1'b0;
        res_valid       = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    word_next   = '0;
                    status_next = STS_OK;
                    state_next  = ST_FINISH;
                    val_next    = req.item_value;
                    unique case (req.action) inside
                        ACT_READ:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                status_next = STS_RANGE;
                            end
                            else
                            begin
                                cmd.rd_en   = 1'b1;
                                cmd.rd_addr = req.position[ADDR_W-1:0];
                                state_next  = ST_READ;
                            end
                        end
                        ACT_WRITE:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                status_next = STS_RANGE;
                            end
                            else
                            begin
                                cmd.wr_en   = 1'b1;
                                cmd.wr_addr = req.position[ADDR_W-1:0];
                                cmd.wr_data = req.item_value;
                            end
                        end
                        ACT_INSERT, ACT_PUSH_FRONT:
                        begin
                            if (full)
                            begin
                                status_next = STS_FULL;
                            end
                            else if (req.action == ACT_INSERT && pos_ext > cnt_ext)
                            begin
                                status_next = STS_RANGE;
                            end
                            else
                            begin
                                // open a gap: walk down from the last element
                                pos_next     = (req.action == ACT_INSERT) ?
                                               req.position[ADDR_W-1:0] : '0;
                                cur_next     = last_addr;
                                rem_next     = (req.action == ACT_INSERT) ?
                                               count_reg - CNT_W'(req.position) :
                                               count_reg;
                                open_next    = 1'b1;
                                capture_next = 1'b0;
                                state_next   = ST_SHIFT;
                            end
                        end
                        ACT_ERASE, ACT_POP_FRONT:
                        begin
                            if (empty)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else if (req.action == ACT_ERASE && pos_ext >= cnt_ext)
                            begin
                                status_next = STS_RANGE;
                            end
                            else
                            begin
                                // close the gap: walk up from the erased element
                                pos_next     = (req.action == ACT_ERASE) ?
                                               req.position[ADDR_W-1:0] : '0;
                                cur_next     = (req.action == ACT_ERASE) ?
                                               req.position[ADDR_W-1:0] : '0;
                                rem_next     = (req.action == ACT_ERASE) ?
                                               count_reg - CNT_W'(req.position) :
                                               count_reg;
                                open_next    = 1'b0;
                                capture_next = (req.action == ACT_POP_FRONT);
                                state_next   = ST_SHIFT;
                            end
                        end
                        ACT_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                status_next = STS_FULL;
                            end
                            else
                            begin
                                cmd.wr_en   = 1'b1;
                                cmd.wr_addr = ADDR_W'(count_reg);
                                cmd.wr_data = req.item_value;
                                count_next  = count_reg + CNT_W'(1);
                            end
                        end
                        ACT_POP_BACK:
                        begin
                            if (empty)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else
                            begin
                                cmd.rd_en   = 1'b1;
                                cmd.rd_addr = last_addr;
                                count_next  = count_reg - CNT_W'(1);
                                state_next  = ST_READ;
                            end
                        end
                        ACT_CLEAR:
                        begin
                            count_next = '0;
                        end
                        ACT_READ_LAST:
                        begin
                            if (empty)
                            begin
                                status_next = STS_EMPTY;
                            end
                            else
                            begin
                                cmd.rd_en   = 1'b1;
                                cmd.rd_addr = last_addr;
                                state_next  = ST_READ;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end

            ST_READ:
            begin
                word_next  = rd_data;
                state_next = ST_FINISH;
            end

            ST_SHIFT:
            begin
                // one read issued and at most one write retired per cycle
                if (rem_reg != '0)
                begin
                    cmd.rd_en       = 1'b1;
                    cmd.rd_addr     = cur_reg;
                    cur_next        = open_reg ? cur_reg - ADDR_W'(1) :
                                                 cur_reg + ADDR_W'(1);
                    rem_next        = rem_reg - CNT_W'(1);
                    pend_valid_next = 1'b1;
                    pend_addr_next  = cur_reg;
                end

                if (pend_valid_reg)
                begin
                    if (open_reg)
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_addr = pend_addr_reg + ADDR_W'(1);
                        cmd.wr_data = rd_data;
                    end
                    else if (pend_addr_reg == pos_reg)
                    begin
                        // first element of the gap is dropped, or returned on pop front
                        if (capture_reg)
                        begin
                            word_next = rd_data;
                        end
                    end
                    else
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_addr = pend_addr_reg - ADDR_W'(1);
                        cmd.wr_data = rd_data;
                    end
                end
                else if (rem_reg == '0)
                begin
                    if (open_reg)
                    begin
                        cmd.wr_en   = 1'b1;
                        cmd.wr_addr = pos_reg;
                        cmd.wr_data = val_reg;
                        count_next  = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        count_next = count_reg - CNT_W'(1);
                    end
                    state_next = ST_FINISH;
                end
            end

            ST_FINISH:
            begin
                res_valid = 1'b1;
                if (res_take)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        res.read_word = word_reg;
        res.status    = status_reg;
        res.count     = count_reg;
        res.is_empty  = (count_reg == '0);
    end

endmodule

`default_nettype wire

// File: sv/bounded_array_list_engine.sv
// bounded list of signed 32-bit words kept in a single-port-write,
// single-port-read ram with a separate element count
// req channel: valid/ready, one transaction per action (read, write,
//   insert, erase, push/pop at either end, clear, read last)
// rsp channel: valid/ready, exactly one transaction per request carrying
//   the word read, status, count after the action and an empty flag
// one request is in flight at a time; a new one is taken the cycle after
// the previous result has moved into the output register
// steps from request acceptance to response valid:
//   write, push back, clear, failed requests and unused codes go straight
//   to the result; read, read last and pop back do one ram read first;
//   insert, push front, erase and pop front walk every element from the
//   position to the end of the list through the ram; the longest walk is
//   an erase at the head or a pop front on a full list
// reset empties the list at once; ram contents are left as they are and
// are never read outside the count
// a stalled receiver holds the response in the output register; one
// further request may complete its work and then waits for the slot
`timescale 1ns / 1ps
`default_nettype none

module bounded_array_list_engine
    import bal_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req,
    output logic      rsp_valid,
    input  wire logic rsp_ready,
    output rsp_t      rsp
);

    ram_cmd_t          cmd;
    logic [WORD_W-1:0] rd_data;
    logic              res_valid;
    rsp_t              res;
    logic              slot_free;
    logic              rsp_valid_reg;
    rsp_t              rsp_reg;

    assign slot_free = !rsp_valid_reg || rsp_ready;

    bal_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_take  (slot_free),
        .res       (res),
        .cmd       (cmd),
        .rd_data   (rd_data)
    );

    bal_ram u_ram (
        .clk     (clk),
        .cmd     (cmd),
        .rd_data (rd_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (slot_free)
        begin
            rsp_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (slot_free && res_valid)
        begin
            rsp_reg <= res;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

// File: sv/bal_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module bal_checker
    import bal_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire req_t req,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire rsp_t rsp
);

    // only one request is taken per turn of the sequencer
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> !req_ready)
        else $error("request taken on consecutive cycles");

    a_empty_flag: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.is_empty == (rsp.count == '0)))
        else $error("empty flag disagrees with count");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp.count <= CNT_W'(CAPACITY)))
        else $error("count above capacity");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp.status != STS_OK) |-> (rsp.read_word == '0))
        else $error("failed transaction returns a word");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
        else $error("response dropped or changed while stalled");

endmodule

bind bounded_array_list_engine bal_checker u_bal_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
);

`default_nettype wire

// File: test/bounded_array_list_engine_test.sv
`timescale 1ns / 1ps

module bounded_array_list_engine_test;
    import bal_pkg::*;

    localparam int RANDOM_ITEMS  = 553;
    localparam int HOLD_CYCLES   = 250;
    localparam int SETTLE_CYCLES = 1100;
    localparam int POS_MAX       = (1 << POS_W) - 1;
    localparam int QUIET_FIRST   = 300;
    localparam int QUIET_LAST    = 450;
    localparam logic [3:0] ACT_UNUSED_FIRST = 4'd10;
    localparam logic [3:0] ACT_UNUSED_LAST  = 4'd15;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    bounded_array_list_engine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    req_t requests_todo[$];
    rsp_t replies_due[$];
    logic signed [WORD_W-1:0] shadow_words [CAPACITY];
    int shadow_len     = 0;
    int gen_len        = 0;
    int total_requests = 0;
    int sent_count     = 0;
    int seen_count     = 0;
    int hold_left      = 0;
    bit hold_done      = 1'b0;
    bit failed         = 1'b0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #4_000_000;
        $display("** bounded_array_list_engine: FAILED **");
        $finish;
    end

    // shadow of the list: works out the reply to one request and updates the contents
    function automatic rsp_t apply_list_action(input req_t r);
        rsp_t o;
        int   p;
        int   k;
        o.read_word = '0;
        o.status    = STS_OK;
        p = int'(r.position);
        case (r.action)
            ACT_READ:
                if (p >= shadow_len) o.status = STS_RANGE;
                else o.read_word = shadow_words[p];
            ACT_WRITE:
                if (p >= shadow_len) o.status = STS_RANGE;
                else shadow_words[p] = r.item_value;
            ACT_INSERT, ACT_PUSH_FRONT:
            begin
                if (r.action == ACT_PUSH_FRONT) p = 0;
                if (shadow_len >= CAPACITY) o.status = STS_FULL;
                else if (p > shadow_len) o.status = STS_RANGE;
                else
                begin
                    for (k = shadow_len; k > p; k--)
                        shadow_words[k] = shadow_words[k-1];
                    shadow_words[p] = r.item_value;
                    shadow_len++;
                end
            end
            ACT_ERASE, ACT_POP_FRONT:
            begin
                if (r.action == ACT_POP_FRONT) p = 0;
                if (shadow_len == 0) o.status = STS_EMPTY;
                else if (p >= shadow_len) o.status = STS_RANGE;
                else
                begin
                    if (r.action == ACT_POP_FRONT) o.read_word = shadow_words[0];
                    for (k = p; k + 1 < shadow_len; k++)
                        shadow_words[k] = shadow_words[k+1];
                    shadow_len--;
                end
            end
            ACT_PUSH_BACK:
                if (shadow_len >= CAPACITY) o.status = STS_FULL;
                else
                begin
                    shadow_words[shadow_len] = r.item_value;
                    shadow_len++;
                end
            ACT_POP_BACK:
                if (shadow_len == 0) o.status = STS_EMPTY;
                else
                begin
                    shadow_len--;
                    o.read_word = shadow_words[shadow_len];
                end
            ACT_CLEAR:
                shadow_len = 0;
            ACT_READ_LAST:
                if (shadow_len == 0) o.status = STS_EMPTY;
                else o.read_word = shadow_words[shadow_len-1];
            default:
                ;
        endcase
        o.count    = shadow_len[CNT_W-1:0];
        o.is_empty = (shadow_len == 0);
        return o;
    endfunction

    // queues a request and keeps a rough length so that positions can be aimed
    function automatic void add_request(input logic [3:0] act, input int pos,
                                        input logic [WORD_W-1:0] value);
        req_t r;
        r.action     = act;
        r.position   = pos[POS_W-1:0];
        r.item_value = value;
        requests_todo.insert(requests_todo.size(), r);
        case (act)
            ACT_INSERT:
                if (gen_len < CAPACITY && r.position <= gen_len) gen_len++;
            ACT_PUSH_BACK, ACT_PUSH_FRONT:
                if (gen_len < CAPACITY) gen_len++;
            ACT_ERASE:
                if (gen_len > 0 && r.position < gen_len) gen_len--;
            ACT_POP_BACK, ACT_POP_FRONT:
                if (gen_len > 0) gen_len--;
            ACT_CLEAR:
                gen_len = 0;
            default:
                ;
        endcase
    endfunction

    function automatic logic [WORD_W-1:0] random_word();
        case ($urandom_range(7))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic int pos_in_list(input int len);
        return (len > 0) ? $urandom_range(len - 1, 0) : 0;
    endfunction

    function automatic int pos_past_end(input int first);
        return $urandom_range(POS_MAX, first);
    endfunction

    function automatic void add_random_request();
        int roll;
        bit aimed;
        roll  = $urandom_range(99);
        aimed = ($urandom_range(99) < 85);
        // keep the list short so that shifts stay cheap
        if (gen_len > 48 && roll >= 24 && roll < 72 && $urandom_range(9) < 7)
            roll = 80;
        if (roll < 12)
            add_request(ACT_READ, (aimed && gen_len > 0) ? pos_in_list(gen_len)
                                                         : pos_past_end(gen_len),
                        random_word());
        else if (roll < 24)
            add_request(ACT_WRITE, (aimed && gen_len > 0) ? pos_in_list(gen_len)
                                                          : pos_past_end(gen_len),
                        random_word());
        else if (roll < 38)
            add_request(ACT_INSERT, aimed ? $urandom_range(gen_len, 0)
                                          : pos_past_end(gen_len + 1),
                        random_word());
        else if (roll < 50)
            add_request(ACT_ERASE, (aimed && gen_len > 0) ? pos_in_list(gen_len)
                                                          : pos_past_end(gen_len),
                        random_word());
        else if (roll < 62)
            add_request(ACT_PUSH_BACK, $urandom_range(POS_MAX), random_word());
        else if (roll < 72)
            add_request(ACT_PUSH_FRONT, $urandom_range(POS_MAX), random_word());
        else if (roll < 80)
            add_request(ACT_POP_BACK, $urandom_range(POS_MAX), random_word());
        else if (roll < 88)
            add_request(ACT_POP_FRONT, $urandom_range(POS_MAX), random_word());
        else if (roll < 90)
            add_request(ACT_CLEAR, $urandom_range(POS_MAX), random_word());
        else if (roll < 95)
            add_request(ACT_READ_LAST, $urandom_range(POS_MAX), random_word());
        else if (roll < 98)
            add_request(4'($urandom_range(ACT_UNUSED_LAST, ACT_UNUSED_FIRST)),
                        $urandom_range(POS_MAX), random_word());
        else
            add_request(4'($urandom_range(15)), $urandom_range(POS_MAX), random_word());
    endfunction

    task automatic compare_field(input string label, input logic [WORD_W-1:0] want,
                                 input logic [WORD_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, label, want, got);
            failed = 1'b1;
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_valid <= 1'b0;
            req       <= '0;
        end
        else
        begin
            if (req_valid && req_ready)
            begin
                replies_due.insert(replies_due.size(), apply_list_action(req));
                sent_count++;
            end
            if (!req_valid || req_ready)
            begin
                if (requests_todo.size() != 0 &&
                    ((sent_count >= QUIET_FIRST && sent_count < QUIET_LAST) ||
                     $urandom_range(99) >= 10))
                begin
                    req       <= requests_todo[0];
                    req_valid <= 1'b1;
                    requests_todo.delete(0);
                end
                else
                    req_valid <= 1'b0;
            end
        end
    end

    // reply monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                seen_count++;
                if (replies_due.size() == 0)
                begin
                    $display("%0t: transaction with nothing expected, actual %p", $time, rsp);
                    failed = 1'b1;
                end
                else
                begin
                    rsp_t want;
                    want = replies_due[0];
                    replies_due.delete(0);
                    compare_field("read_word", want.read_word, rsp.read_word);
                    compare_field("status", WORD_W'(want.status), WORD_W'(rsp.status));
                    compare_field("count", WORD_W'(want.count), WORD_W'(rsp.count));
                    compare_field("is_empty", WORD_W'(want.is_empty),
                                  WORD_W'(rsp.is_empty));
                end
            end
            // one long hold-off so that the engine backs up into its input
            if (hold_left > 0)
            begin
                hold_left--;
                rsp_ready <= 1'b0;
            end
            else if (!hold_done && seen_count >= 60)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES;
                rsp_ready <= 1'b0;
            end
            else
                rsp_ready <= (seen_count >= QUIET_FIRST && seen_count < QUIET_LAST) ||
                             ($urandom_range(99) >= 10);
        end
    end

    initial
    begin
        // empty list corner cases
        add_request(ACT_READ, 0, random_word());
        add_request(ACT_WRITE, 0, random_word());
        add_request(ACT_ERASE, 0, random_word());
        add_request(ACT_POP_BACK, 0, random_word());
        add_request(ACT_POP_FRONT, POS_MAX, random_word());
        add_request(ACT_READ_LAST, 0, random_word());
        // build a short list and walk the index checks
        add_request(ACT_PUSH_BACK, 0, 32'h7fff_ffff);
        add_request(ACT_PUSH_FRONT, 0, 32'h8000_0000);
        add_request(ACT_INSERT, 1, 32'hffff_ffff);
        add_request(ACT_INSERT, 3, 32'h0000_0000);
        add_request(ACT_INSERT, 5, 32'h1234_5678);
        add_request(ACT_INSERT, POS_MAX, 32'h1234_5678);
        add_request(ACT_READ, 2, '0);
        add_request(ACT_WRITE, 1, 32'h5a5a_a5a5);
        add_request(ACT_WRITE, 4, 32'h0bad_0bad);
        add_request(ACT_READ, CAPACITY, '0);
        add_request(ACT_READ_LAST, 0, '0);
        add_request(ACT_ERASE, 4, '0);
        add_request(ACT_ERASE, 1, '0);
        add_request(ACT_ERASE, 2, '0);
        add_request(ACT_POP_FRONT, 0, '0);
        add_request(ACT_POP_BACK, 0, '0);
        add_request(ACT_PUSH_BACK, 0, 32'h0000_0001);
        add_request(ACT_CLEAR, 0, '0);
        add_request(ACT_CLEAR, POS_MAX, '1);
        add_request(ACT_UNUSED_LAST, POS_MAX, '1);
        add_request(ACT_UNUSED_FIRST, 0, '0);

        repeat (RANDOM_ITEMS) add_random_request();

        total_requests = requests_todo.size();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_count < total_requests || replies_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (!failed)
            $display("** bounded_array_list_engine: PASSED **");
        else
            $display("** bounded_array_list_engine: FAILED **");
        $finish;
    end

endmodule

// File: filelist.f
sv/bal_pkg.sv
sv/bal_ram.sv
sv/bal_ctrl.sv
sv/bounded_array_list_engine.sv
sv/bal_checker.sv
test/bounded_array_list_engine_test.sv
